@@ rtl/dose_alarm_scheduler_macros.svh @@
// ---------------------------------------------------------------------------
// Dose alarm scheduler assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef DOSE_ALARM_SCHEDULER_MACROS_SVH
`define DOSE_ALARM_SCHEDULER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define DAS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/das_pkg.sv @@
// ---------------------------------------------------------------------------
// Dose alarm scheduler package
// Widths, register indexes, day constants, slot spacing table and the
// request/response types of the shared minute unit.
// ---------------------------------------------------------------------------
package das_pkg;

    localparam int HOUR_W     = 5;
    localparam int MINSEC_W   = 6;
    localparam int MASK_W     = 3;
    localparam int DOSE_W     = 4;
    localparam int SLOT_W     = 4;
    localparam int MIN_W      = 11;
    localparam int CNT_W      = 5;
    localparam int CFG_COMP   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [MIN_W:0]      DAY_MINUTES    = 12'(24 * 60);
    localparam logic [MINSEC_W-1:0] HOUR_MINUTES   = 6'd60;
    localparam logic [MINSEC_W-1:0] WINDOW_SECONDS = 6'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOSES_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOSES_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOSES_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_A     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_B     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_C     = 3'd6;

    typedef struct packed {
        logic [MIN_W-1:0] base;
        logic [MIN_W-1:0] addend;
        logic [MIN_W-1:0] target;
    } das_step_req_t;

    typedef struct packed {
        logic [MIN_W-1:0] wrapped;
        logic             hit;
    } das_step_rsp_t;

    // Spacing in minutes between doses for a clamped dose count.
    function automatic logic [MIN_W-1:0] gap_for(input logic [CNT_W-1:0] n);
        logic [MIN_W-1:0] g;
        case (n)
            5'd2:    g = 11'd720;
            5'd3:    g = 11'd480;
            5'd4:    g = 11'd360;
            5'd5:    g = 11'd288;
            5'd6:    g = 11'd240;
            5'd7:    g = 11'd205;
            5'd8:    g = 11'd180;
            5'd9:    g = 11'd160;
            5'd10:   g = 11'd144;
            5'd11:   g = 11'd130;
            5'd12:   g = 11'd120;
            5'd13:   g = 11'd110;
            5'd14:   g = 11'd102;
            5'd15:   g = 11'd96;
            5'd16:   g = 11'd90;
            default: g = 11'd0;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/das_step_unit.sv @@
// ---------------------------------------------------------------------------
// Dose alarm scheduler minute unit
// Shared adder with wrap at one day and slot-minute compare.
// ---------------------------------------------------------------------------
module das_step_unit
    import das_pkg::*;
(
    input  das_step_req_t req,
    output das_step_rsp_t rsp
);

    logic [MIN_W:0] sum;
    logic [MIN_W:0] sum_wrapped;

    always_comb
    begin
        sum         = {1'b0, req.base} + {1'b0, req.addend};
        sum_wrapped = (sum >= DAY_MINUTES) ? (sum - DAY_MINUTES) : sum;
        rsp.wrapped = sum_wrapped[MIN_W-1:0];
        rsp.hit     = (req.base == req.target);
    end

endmodule

@@ rtl/dose_alarm_scheduler.sv @@
// ---------------------------------------------------------------------------
// Dose alarm scheduler
// Per-tick dose alarm raise, lid acknowledge and midnight clear for a set of
// pill compartments, walking dose slots through one shared minute unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one polling tick: clock_hour,
//   clock_minute, clock_second and lid_open. Each tick yields exactly one
//   request on the output channel (out_valid/out_ready) with the alarm,
//   fired and taken masks, the last alarmed slot of each compartment and
//   day_cleared.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes the active
//   mask, dose counts and start minutes; write it only while idle.
//   Sequence: a tick is accepted while idle, then each compartment passes
//   through load, a walk over s slots (0 up to DOSE_SLOTS) and finish,
//   and the result is written in the output step. The shared minute
//   adder steps one slot per cycle.
//   in_ready is high while the sequencer is idle; a finished result sits
//   in the output register, and a new tick is taken while it waits.
//   If the receiver stalls, the next tick finishes and waits in its final
//   step until the output register frees.
//   Reset clears configuration, taken marks, alarms and slots to zero.
// ---------------------------------------------------------------------------
`include "dose_alarm_scheduler_macros.svh"

module dose_alarm_scheduler
    import das_pkg::*;
#(
    parameter int COMPARTMENTS = 3,
    parameter int DOSE_SLOTS   = 9
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [HOUR_W-1:0]     clock_hour,
    input  logic [MINSEC_W-1:0]   clock_minute,
    input  logic [MINSEC_W-1:0]   clock_second,
    input  logic [MASK_W-1:0]     lid_open,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MASK_W-1:0]     alarm_mask,
    output logic [MASK_W-1:0]     fired_mask,
    output logic [MASK_W-1:0]     taken_mask,
    output logic [SLOT_W-1:0]     alarm_slot_a,
    output logic [SLOT_W-1:0]     alarm_slot_b,
    output logic [SLOT_W-1:0]     alarm_slot_c,
    output logic                  day_cleared
);

    localparam int CW    = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
    localparam int SHOWN = (COMPARTMENTS < CFG_COMP) ? COMPARTMENTS : CFG_COMP;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [MASK_W-1:0]     active_mask_reg;
    logic [DOSE_W-1:0]     doses_reg [CFG_COMP];
    logic [MIN_W-1:0]      start_reg [CFG_COMP];

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         comp_reg, comp_next;
    logic [SLOT_W-1:0]     slot_idx_reg, slot_idx_next;
    logic [MIN_W-1:0]      cur_min_reg, cur_min_next;
    logic [MIN_W-1:0]      target_reg, target_next;
    logic                  win_reg, win_next;
    logic                  clear_reg, clear_next;
    logic [MASK_W-1:0]     lid_reg, lid_next;
    logic [MASK_W-1:0]     fired_acc_reg, fired_acc_next;
    logic [MASK_W-1:0]     taken_acc_reg, taken_acc_next;

    logic [DOSE_SLOTS-1:0] taken_reg [COMPARTMENTS];
    logic [DOSE_SLOTS-1:0] taken_next [COMPARTMENTS];
    logic                  raised_reg [COMPARTMENTS];
    logic                  raised_next [COMPARTMENTS];
    logic [SLOT_W-1:0]     slot_reg [COMPARTMENTS];
    logic [SLOT_W-1:0]     slot_next [COMPARTMENTS];

    logic                  out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]     alarm_mask_reg, alarm_mask_next;
    logic [MASK_W-1:0]     fired_mask_reg, fired_mask_next;
    logic [MASK_W-1:0]     taken_mask_reg, taken_mask_next;
    logic [SLOT_W-1:0]     slot_out_reg [CFG_COMP];
    logic [SLOT_W-1:0]     slot_out_next [CFG_COMP];
    logic                  day_cleared_reg, day_cleared_next;

    logic                  cur_active;
    logic                  cur_lid;
    logic [DOSE_W-1:0]     cur_doses;
    logic [MIN_W-1:0]      cur_start;
    logic [CNT_W-1:0]      cur_n;
    logic [MIN_W-1:0]      cur_gap;
    logic [DOSE_SLOTS-1:0] cur_taken;
    logic [DOSE_SLOTS-1:0] taken_shift;
    logic [DOSE_SLOTS-1:0] taken_cleared;
    logic                  cur_raised;
    logic [SLOT_W-1:0]     cur_slot;
    logic                  last_slot;
    logic                  last_comp;
    logic [MASK_W-1:0]     comp_bit;
    logic [MASK_W-1:0]     alarm_vec;
    logic [MIN_W-1:0]      hour_minutes;
    logic                  in_fire;
    logic                  out_free;

    das_step_req_t         step_req;
    das_step_rsp_t         step_rsp;

    das_step_unit u_step
    (
        .req (step_req),
        .rsp (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mask_reg <= '0;
            for (int i = 0; i < CFG_COMP; i++)
            begin
                doses_reg[i] <= '0;
                start_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTIVE_MASK: active_mask_reg <= cfg_wdata[MASK_W-1:0];
                REG_DOSES_A:     doses_reg[0]    <= cfg_wdata[DOSE_W-1:0];
                REG_DOSES_B:     doses_reg[1]    <= cfg_wdata[DOSE_W-1:0];
                REG_DOSES_C:     doses_reg[2]    <= cfg_wdata[DOSE_W-1:0];
                REG_START_A:     start_reg[0]    <= cfg_wdata[MIN_W-1:0];
                REG_START_B:     start_reg[1]    <= cfg_wdata[MIN_W-1:0];
                REG_START_C:     start_reg[2]    <= cfg_wdata[MIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cur_active = 1'b0;
        cur_lid    = 1'b0;
        cur_doses  = '0;
        cur_start  = '0;
        comp_bit   = '0;
        for (int i = 0; i < CFG_COMP; i++)
        begin
            if (int'(comp_reg) == i)
            begin
                cur_active  = active_mask_reg[i];
                cur_lid     = lid_reg[i];
                cur_doses   = doses_reg[i];
                cur_start   = start_reg[i];
                comp_bit[i] = 1'b1;
            end
        end
        cur_n = ({1'b0, cur_doses} > CNT_W'(DOSE_SLOTS)) ? CNT_W'(DOSE_SLOTS)
                                                         : {1'b0, cur_doses};
        cur_gap     = gap_for(cur_n);
        cur_taken   = taken_reg[comp_reg];
        cur_raised  = raised_reg[comp_reg];
        cur_slot    = slot_reg[comp_reg];
        taken_shift = cur_taken >> slot_idx_reg;
        last_slot   = (({1'b0, slot_idx_reg} + CNT_W'(1)) == cur_n);
        last_comp   = (int'(comp_reg) == COMPARTMENTS - 1);

        taken_cleared = clear_reg ? '0 : cur_taken;

        alarm_vec = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            alarm_vec[i] = raised_reg[i];
        end

        step_req.base   = (state_reg == S_LOAD) ? cur_start : cur_min_reg;
        step_req.addend = (state_reg == S_LOAD) ? '0 : cur_gap;
        step_req.target = target_reg;

        hour_minutes = {clock_hour, 6'b000000} - MIN_W'({clock_hour, 2'b00});
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        comp_next        = comp_reg;
        slot_idx_next    = slot_idx_reg;
        cur_min_next     = cur_min_reg;
        target_next      = target_reg;
        win_next         = win_reg;
        clear_next       = clear_reg;
        lid_next         = lid_reg;
        fired_acc_next   = fired_acc_reg;
        taken_acc_next   = taken_acc_reg;
        taken_next       = taken_reg;
        raised_next      = raised_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        alarm_mask_next  = alarm_mask_reg;
        fired_mask_next  = fired_mask_reg;
        taken_mask_next  = taken_mask_reg;
        slot_out_next    = slot_out_reg;
        day_cleared_next = day_cleared_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    target_next    = hour_minutes + MIN_W'(clock_minute);
                    win_next       = (clock_second < WINDOW_SECONDS)
                                     && (clock_minute < HOUR_MINUTES);
                    clear_next     = (clock_hour == '0) && (clock_minute == '0)
                                     && (clock_second < WINDOW_SECONDS);
                    lid_next       = lid_open;
                    comp_next      = '0;
                    fired_acc_next = '0;
                    taken_acc_next = '0;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cur_min_next  = step_rsp.wrapped;
                slot_idx_next = '0;
                if (!cur_active || cur_raised || !win_reg || (cur_n == '0))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (step_rsp.hit && !taken_shift[0])
                begin
                    raised_next[comp_reg] = 1'b1;
                    slot_next[comp_reg]   = slot_idx_reg;
                    fired_acc_next        = fired_acc_reg | comp_bit;
                    state_next            = S_FINISH;
                end
                else if (last_slot)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + SLOT_W'(1);
                    cur_min_next  = step_rsp.wrapped;
                end
            end
            S_FINISH:
            begin
                taken_next[comp_reg] = taken_cleared;
                if (cur_active && cur_raised && cur_lid)
                begin
                    for (int j = 0; j < DOSE_SLOTS; j++)
                    begin
                        if (int'(cur_slot) == j)
                        begin
                            taken_next[comp_reg][j] = 1'b1;
                        end
                    end
                    raised_next[comp_reg] = 1'b0;
                    taken_acc_next        = taken_acc_reg | comp_bit;
                end
                if (last_comp)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + CW'(1);
                    state_next = S_LOAD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    alarm_mask_next  = alarm_vec;
                    fired_mask_next  = fired_acc_reg;
                    taken_mask_next  = taken_acc_reg;
                    day_cleared_next = clear_reg;
                    for (int i = 0; i < CFG_COMP; i++)
                    begin
                        slot_out_next[i] = '0;
                    end
                    for (int i = 0; i < SHOWN; i++)
                    begin
                        slot_out_next[i] = slot_reg[i];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= '0;
            slot_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COMPARTMENTS; i++)
            begin
                taken_reg[i]  <= '0;
                raised_reg[i] <= 1'b0;
                slot_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            slot_idx_reg  <= slot_idx_next;
            out_valid_reg <= out_valid_next;
            taken_reg     <= taken_next;
            raised_reg    <= raised_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_min_reg     <= cur_min_next;
        target_reg      <= target_next;
        win_reg         <= win_next;
        clear_reg       <= clear_next;
        lid_reg         <= lid_next;
        fired_acc_reg   <= fired_acc_next;
        taken_acc_reg   <= taken_acc_next;
        alarm_mask_reg  <= alarm_mask_next;
        fired_mask_reg  <= fired_mask_next;
        taken_mask_reg  <= taken_mask_next;
        slot_out_reg    <= slot_out_next;
        day_cleared_reg <= day_cleared_next;
    end

    assign out_valid    = out_valid_reg;
    assign alarm_mask   = alarm_mask_reg;
    assign fired_mask   = fired_mask_reg;
    assign taken_mask   = taken_mask_reg;
    assign alarm_slot_a = slot_out_reg[0];
    assign alarm_slot_b = slot_out_reg[1];
    assign alarm_slot_c = slot_out_reg[2];
    assign day_cleared  = day_cleared_reg;

    `DAS_ASSERT_NEXT(a_accept_loads, in_fire, state_reg == S_LOAD,
        "accepted request did not start the slot walk")
    `DAS_ASSERT_SAME(a_scan_in_window, state_reg == S_SCAN, win_reg,
        "slot walk outside the alarm window")
    `DAS_ASSERT_SAME(a_slot_in_range, state_reg == S_SCAN,
        CNT_W'(slot_idx_reg) < cur_n, "slot index beyond slot count")
    `DAS_ASSERT_SAME(a_fired_raised, state_reg == S_OUT,
        (fired_acc_reg & ~taken_acc_reg & ~alarm_vec) == '0,
        "fired alarm neither raised nor acknowledged")

endmodule

@@ bench/dose_alarm_scheduler_test.sv @@
// ---------------------------------------------------------------------------
// Dose alarm scheduler testbench
// Drives polling ticks through the valid/ready input channel under random
// bursts and gaps, stalls the result channel on its own pattern, and checks
// every result field against a tick-by-tick schedule predictor that keeps
// its own copy of the dose configuration, taken marks and raised alarms.
// Runs a directed pass over the special cases, then random phases across
// several schedule settings, the extremes among them.
// ---------------------------------------------------------------------------
module dose_alarm_scheduler_test;
    import das_pkg::*;

    localparam int COMPS      = 3;
    localparam int SLOTS      = 9;
    localparam int DAY_MIN    = 24 * 60;
    localparam int HOUR_MIN   = 60;
    localparam int WINDOW     = 5;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_TICKS = 80;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINSEC_W-1:0] minute;
        logic [MINSEC_W-1:0] second;
        logic [MASK_W-1:0]   lid;
    } tick_t;

    typedef struct packed {
        logic [MASK_W-1:0] alarm;
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] taken;
        logic [SLOT_W-1:0] slot_a;
        logic [SLOT_W-1:0] slot_b;
        logic [SLOT_W-1:0] slot_c;
        logic              cleared;
    } dose_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [HOUR_W-1:0]     clock_hour = '0;
    logic [MINSEC_W-1:0]   clock_minute = '0;
    logic [MINSEC_W-1:0]   clock_second = '0;
    logic [MASK_W-1:0]     lid_open = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MASK_W-1:0]     alarm_mask;
    logic [MASK_W-1:0]     fired_mask;
    logic [MASK_W-1:0]     taken_mask;
    logic [SLOT_W-1:0]     alarm_slot_a;
    logic [SLOT_W-1:0]     alarm_slot_b;
    logic [SLOT_W-1:0]     alarm_slot_c;
    logic                  day_cleared;

    dose_alarm_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second),
        .lid_open     (lid_open),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .alarm_mask   (alarm_mask),
        .fired_mask   (fired_mask),
        .taken_mask   (taken_mask),
        .alarm_slot_a (alarm_slot_a),
        .alarm_slot_b (alarm_slot_b),
        .alarm_slot_c (alarm_slot_c),
        .day_cleared  (day_cleared)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // schedule copy and predicted state
    logic [MASK_W-1:0] sched_active;
    logic [DOSE_W-1:0] sched_doses [COMPS];
    logic [MIN_W-1:0]  sched_start [COMPS];
    logic [SLOTS-1:0]  taken_marks [COMPS];
    logic              alarm_up [COMPS];
    logic [SLOT_W-1:0] alarmed_slot [COMPS];

    tick_t        tick_q [$];
    dose_report_t report_q [$];
    int           queued_total = 0;
    int           checked_total = 0;
    int           error_count = 0;
    int           fired_total = 0;
    int           taken_total = 0;
    int           clear_total = 0;
    int           idle_cycles = 0;
    logic         in_fire = 1'b0;

    function automatic int slots_of(int c);
        return (sched_doses[c] > SLOTS) ? SLOTS : int'(sched_doses[c]);
    endfunction

    function automatic int dose_minute(int c, int d);
        int n;
        int spacing;
        n = slots_of(c);
        spacing = (n > 1) ? DAY_MIN / n : 0;
        return (int'(sched_start[c]) + d * spacing) % DAY_MIN;
    endfunction

    function automatic dose_report_t advance_schedule(tick_t t);
        dose_report_t r;
        int m;
        logic found;
        r = '0;
        for (int c = 0; c < COMPS; c++)
        begin
            if (sched_active[c] && !alarm_up[c])
            begin
                found = 1'b0;
                for (int d = 0; d < slots_of(c); d++)
                begin
                    if (!found && !taken_marks[c][d])
                    begin
                        m = dose_minute(c, d);
                        if (m / HOUR_MIN == t.hour && m % HOUR_MIN == t.minute
                            && t.second < WINDOW)
                        begin
                            alarm_up[c] = 1'b1;
                            alarmed_slot[c] = SLOT_W'(d);
                            r.fired[c] = 1'b1;
                            found = 1'b1;
                            fired_total++;
                        end
                    end
                end
            end
        end
        r.cleared = (t.hour == 0 && t.minute == 0 && t.second < WINDOW);
        if (r.cleared)
        begin
            clear_total++;
            for (int c = 0; c < COMPS; c++)
                taken_marks[c] = '0;
        end
        for (int c = 0; c < COMPS; c++)
        begin
            if (sched_active[c] && alarm_up[c] && t.lid[c])
            begin
                taken_marks[c][alarmed_slot[c]] = 1'b1;
                alarm_up[c] = 1'b0;
                r.taken[c] = 1'b1;
                taken_total++;
            end
        end
        for (int c = 0; c < COMPS; c++)
            r.alarm[c] = alarm_up[c];
        r.slot_a = alarmed_slot[0];
        r.slot_b = alarmed_slot[1];
        r.slot_c = alarmed_slot[2];
        return r;
    endfunction

    function automatic tick_t clock_tick(int h, int m, int s, int lid);
        tick_t t;
        t.hour = HOUR_W'(h);
        t.minute = MINSEC_W'(m);
        t.second = MINSEC_W'(s);
        t.lid = MASK_W'(lid);
        return t;
    endfunction

    function automatic tick_t dose_tick(int c, int d, int s, int lid);
        int m;
        m = dose_minute(c, d);
        return clock_tick(m / HOUR_MIN, m % HOUR_MIN, s, lid);
    endfunction

    function automatic tick_t random_tick();
        int r;
        int c;
        int n;
        int lid;
        int sec;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, COMPS - 1);
        n = slots_of(c);
        lid = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
        sec = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        if (r < 55 && n > 0)
            return dose_tick(c, $urandom_range(0, n - 1), sec, lid);
        else if (r < 65)
            return clock_tick(0, 0, $urandom_range(0, 6), lid);
        else if (r < 80)
            return clock_tick($urandom_range(0, 23), $urandom_range(0, 59),
                              $urandom_range(0, 59), $urandom_range(0, 7));
        else
            return clock_tick($urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 7));
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch on result %0d: %s", $realtime, checked_total, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic queue_tick(tick_t t);
        tick_q.push_back(t);
        queued_total++;
    endtask

    task automatic wait_drained();
        while (checked_total != queued_total)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int width);
        logic [CFG_DATA_W-1:0] wd;
        wd = CFG_DATA_W'(($urandom << width) | value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wd;
        case (idx)
            REG_ACTIVE_MASK: sched_active = wd[MASK_W-1:0];
            REG_DOSES_A, REG_DOSES_B, REG_DOSES_C:
                sched_doses[idx - REG_DOSES_A] = wd[DOSE_W-1:0];
            REG_START_A, REG_START_B, REG_START_C:
                sched_start[idx - REG_START_A] = wd[MIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_schedule(int mask, int da, int db, int dc,
                                    int sa, int sb, int sc);
        write_reg(REG_ACTIVE_MASK, mask, MASK_W);
        write_reg(REG_DOSES_A, da, DOSE_W);
        write_reg(REG_DOSES_B, db, DOSE_W);
        write_reg(REG_DOSES_C, dc, DOSE_W);
        write_reg(REG_START_A, sa, MIN_W);
        write_reg(REG_START_B, sb, MIN_W);
        write_reg(REG_START_C, sc, MIN_W);
    endtask

    // tick sender: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : send_ticks
        tick_t next_tick;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (tick_q.size() > 0)
        begin
            next_tick = tick_q.pop_front();
            clock_hour <= next_tick.hour;
            clock_minute <= next_tick.minute;
            clock_second <= next_tick.second;
            lid_open <= next_tick.lid;
            in_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0: gap_left <= 0;
                    1: gap_left <= $urandom_range(0, 3);
                    2: gap_left <= $urandom_range(0, 12);
                    default: gap_left <= $urandom_range(20, 45);
                endcase
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // result receiver: switches at random between always ready, random ready and long stalls
    int ready_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
        end
        else
            mode_left <= mode_left - 1;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default:
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left <= $urandom_range(4, 60);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
            endcase
    end

    always @(posedge clk)
    begin : check_reports
        dose_report_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                    report_mismatch("result with no tick outstanding");
                else
                begin
                    want = report_q.pop_front();
                    check_field("alarm_mask", 4'(alarm_mask), 4'(want.alarm));
                    check_field("fired_mask", 4'(fired_mask), 4'(want.fired));
                    check_field("taken_mask", 4'(taken_mask), 4'(want.taken));
                    check_field("alarm_slot_a", alarm_slot_a, want.slot_a);
                    check_field("alarm_slot_b", alarm_slot_b, want.slot_b);
                    check_field("alarm_slot_c", alarm_slot_c, want.slot_c);
                    check_field("day_cleared", 4'(day_cleared), 4'(want.cleared));
                    checked_total++;
                end
            end
            if (in_valid && in_ready)
                report_q.push_back(advance_schedule(
                    clock_tick(clock_hour, clock_minute, clock_second, lid_open)));
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || checked_total == queued_total)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] timeout: no request moved for %0d cycles",
                         $realtime, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        sched_active = '0;
        for (int c = 0; c < COMPS; c++)
        begin
            sched_doses[c] = '0;
            sched_start[c] = '0;
            taken_marks[c] = '0;
            alarm_up[c] = 1'b0;
            alarmed_slot[c] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: midnight window, alarm window edge, wrap, clamp, bad clock
        program_schedule(7, 9, 1, 15, 0, 1439, 2047);
        queue_tick(clock_tick(0, 0, 0, 0));
        queue_tick(clock_tick(0, 0, 1, 0));
        queue_tick(clock_tick(0, 0, 2, 1));
        queue_tick(clock_tick(0, 0, 3, 0));
        queue_tick(clock_tick(0, 0, 4, 0));
        queue_tick(clock_tick(0, 0, 5, 7));
        queue_tick(dose_tick(1, 0, 4, 0));
        queue_tick(dose_tick(1, 0, 5, 2));
        queue_tick(dose_tick(0, 1, 5, 0));
        queue_tick(dose_tick(0, 1, 0, 0));
        queue_tick(dose_tick(2, 0, 3, 4));
        queue_tick(dose_tick(2, 8, 0, 6));
        queue_tick(clock_tick(31, 63, 63, 7));
        queue_tick(clock_tick(24, 0, 0, 0));
        queue_tick(clock_tick(0, 60, 0, 0));
        queue_tick(clock_tick(0, 0, 63, 0));
        queue_tick(dose_tick(1, 0, 0, 0));
        queue_tick(dose_tick(0, 8, 2, 1));
        wait_drained();

        // drop a compartment while its alarm is up, then bring it back
        queue_tick(dose_tick(0, 3, 0, 0));
        wait_drained();
        write_reg(REG_ACTIVE_MASK, 6, MASK_W);
        write_reg(REG_DOSES_B, 0, DOSE_W);
        write_reg(REG_UNUSED, $urandom_range(0, 2047), 0);
        queue_tick(clock_tick(12, 0, 30, 7));
        queue_tick(clock_tick(23, 59, 0, 0));
        wait_drained();
        write_reg(REG_ACTIVE_MASK, 7, MASK_W);
        queue_tick(clock_tick(12, 1, 0, 1));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: program_schedule(7, 9, 9, 9, 1439, 0, 720);
                1: program_schedule(7, 15, 15, 15, 2047, 1440, 1500);
                2: program_schedule(0, 9, 1, 2, 0, 60, 600);
                default:
                    program_schedule($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 7,
                                     $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 15), $urandom_range(0, 2047),
                                     $urandom_range(0, 2047), $urandom_range(0, 2047));
            endcase
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // hold the sender until every outstanding result is back
                if (i == PHASE_TICKS / 2)
                    wait_drained();
                queue_tick(random_tick());
            end
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (report_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", report_q.size()));
        $display("Covered %0d ticks over the directed cases and 6 random schedules: %0d alarms raised,",
                 queued_total, fired_total);
        $display("%0d doses taken by lid, %0d midnight clears, %0d mismatches.",
                 taken_total, clear_total, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
